@@ rtl/lmfc_pkg.sv @@
// Shared types and constants for the move-to-front LRU cache.
package lmfc_pkg;

  localparam int ENTRIES  = 8;
  localparam int KEY_BITS = 32;

  typedef logic [KEY_BITS-1:0] key_t;

  typedef enum logic [1:0] {
    ACT_INSERT     = 2'd0,
    ACT_LOOKUP     = 2'd1,
    ACT_INVALIDATE = 2'd2,
    ACT_FLUSH      = 2'd3
  } action_t;

  typedef enum logic {
    PH_IDLE  = 1'b0,
    PH_APPLY = 1'b1
  } phase_t;

  typedef struct packed {
    logic        valid;
    key_t        key;
    logic [31:0] handle;
    logic [15:0] count;
  } entry_t;

  // Control that the sequencer broadcasts to every cell of the chain.
  typedef struct packed {
    logic capture;
    logic flush;
    logic shift_all;
    logic promote;
  } cell_ctrl_t;

endpackage

@@ rtl/lru_move_to_front_cache_unit.sv @@
// Top level of the move-to-front LRU cache: sequencer and chain of slot cells.
//
//   channel   | signals                              | handshake
//   ----------+--------------------------------------+------------------------------
//   request   | action, key, handle, item_count      | taken when start && !busy
//   result    | hit, found_handle, found_count       | shown for one cycle with done
//
// Each transaction has two steps: every cell compares its key as the request is
// accepted, and the chain shifts and the front slot loads while busy is high,
// which is for one cycle after each accepted request. The result is registered
// from that busy cycle, while the next request may already be accepted. Reset
// empties the cache at once. The receiver cannot stall the result.
module lru_move_to_front_cache_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  action,
  input  logic [31:0] key,
  input  logic [31:0] handle,
  input  logic [15:0] item_count,
  output logic        done,
  output logic        hit,
  output logic [31:0] found_handle,
  output logic [15:0] found_count
);

  lmfc_pkg::phase_t     phase;
  lmfc_pkg::phase_t     phase_next;
  lmfc_pkg::action_t    act_q;
  lmfc_pkg::key_t       key_q;
  lmfc_pkg::key_t       lookup_key;
  logic [31:0]          handle_q;
  logic [15:0]          count_q;
  lmfc_pkg::cell_ctrl_t ctl;
  lmfc_pkg::entry_t     front;
  lmfc_pkg::entry_t     sel_any;
  lmfc_pkg::entry_t     slots  [lmfc_pkg::ENTRIES];
  lmfc_pkg::entry_t     sels   [lmfc_pkg::ENTRIES];
  logic [lmfc_pkg::ENTRIES:0] found;
  logic                 accept;
  logic                 apply;
  logic                 hit_any;
  logic                 hit_res;

  assign accept     = start && !busy;
  assign lookup_key = lmfc_pkg::key_t'(key);
  assign found[0]   = 1'b0;
  assign hit_any    = found[lmfc_pkg::ENTRIES];

  always_comb begin
    unique case (phase)
      lmfc_pkg::PH_IDLE:  phase_next = accept ? lmfc_pkg::PH_APPLY : lmfc_pkg::PH_IDLE;
      lmfc_pkg::PH_APPLY: phase_next = lmfc_pkg::PH_IDLE;
      default:            phase_next = lmfc_pkg::PH_IDLE;
    endcase
  end

  always_comb begin
    busy  = (phase == lmfc_pkg::PH_APPLY);
    apply = busy;
    ctl.capture   = accept;
    ctl.flush     = apply && (act_q == lmfc_pkg::ACT_FLUSH);
    ctl.promote   = apply && (act_q != lmfc_pkg::ACT_FLUSH);
    ctl.shift_all = apply && (act_q == lmfc_pkg::ACT_INSERT) && !hit_any;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= lmfc_pkg::PH_IDLE;
    end else begin
      phase <= phase_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      act_q    <= lmfc_pkg::action_t'(action);
      key_q    <= lookup_key;
      handle_q <= handle;
      count_q  <= item_count;
    end
  end

  always_comb begin
    sel_any = '0;
    for (int i = 0; i < lmfc_pkg::ENTRIES; i++) begin
      sel_any = sel_any | sels[i];
    end
  end

  // What enters the front slot: a new entry, the promoted one, or a cleared slot.
  always_comb begin
    if (act_q == lmfc_pkg::ACT_INSERT && !hit_any) begin
      front.valid  = 1'b1;
      front.key    = key_q;
      front.handle = handle_q;
      front.count  = count_q;
    end else if (act_q == lmfc_pkg::ACT_INVALIDATE) begin
      front = '0;
    end else begin
      front = sel_any;
    end
  end

  for (genvar g = 0; g < lmfc_pkg::ENTRIES; g++) begin : g_cell
    lmfc_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctl        (ctl),
      .lookup_key (lookup_key),
      .prev       ((g == 0) ? front : slots[(g == 0) ? 0 : g - 1]),
      .found_in   (found[g]),
      .hit_any    (hit_any),
      .slot       (slots[g]),
      .sel        (sels[g]),
      .found_out  (found[g+1])
    );
  end

  assign hit_res = hit_any && (act_q != lmfc_pkg::ACT_FLUSH);

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= apply;
    end
  end

  always_ff @(posedge clk) begin
    if (apply) begin
      hit          <= hit_res;
      found_handle <= hit_res ? sel_any.handle : 32'd0;
      found_count  <= hit_res ? sel_any.count : 16'd0;
    end
  end

endmodule

@@ rtl/lmfc_cell.sv @@
// One slot of the most-recent-first list: storage, key compare and shift.
module lmfc_cell (
  input  logic                clk,
  input  logic                rst,
  input  lmfc_pkg::cell_ctrl_t ctl,
  input  lmfc_pkg::key_t      lookup_key,
  input  lmfc_pkg::entry_t    prev,
  input  logic                found_in,
  input  logic                hit_any,
  output lmfc_pkg::entry_t    slot,
  output lmfc_pkg::entry_t    sel,
  output logic                found_out
);

  logic match;
  logic shift_here;

  // On a hit, every slot up to and including the first match moves back one.
  assign shift_here = ctl.shift_all | (ctl.promote & hit_any & ~found_in);
  assign found_out  = found_in | match;
  assign sel        = (match & ~found_in) ? slot : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      slot  <= '0;
      match <= 1'b0;
    end else begin
      if (ctl.capture) begin
        match <= slot.valid && (slot.key == lookup_key);
      end
      if (ctl.flush) begin
        slot <= '0;
      end else if (shift_here) begin
        slot <= prev;
      end
    end
  end

endmodule

@@ rtl/lmfc_checker.sv @@
// Port-level checks on the cache's transaction timing and result values.
module lmfc_checker (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        done,
  input logic        hit,
  input logic [31:0] found_handle,
  input logic [15:0] found_count
);

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("busy did not rise after an accepted transaction");

  a_done_latency: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> ##1 done)
    else $error("result missing two cycles after an accepted transaction");

  a_done_follows_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result without a preceding busy cycle");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    done && !hit |-> (found_handle == 32'd0) && (found_count == 16'd0))
    else $error("nonzero payload reported on a miss");

endmodule

bind lru_move_to_front_cache_unit lmfc_checker u_lmfc_checker (.*);

@@ sim/lru_move_to_front_cache_unit_tb.sv @@
// Self-checking testbench for the move-to-front LRU cache unit.
module lru_move_to_front_cache_unit_tb;

  typedef struct packed {
    lmfc_pkg::action_t act;
    logic [31:0]       key;
    logic [31:0]       handle;
    logic [15:0]       cnt;
  } request_t;

  typedef struct packed {
    logic        hit;
    logic [31:0] handle;
    logic [15:0] cnt;
  } reply_t;

  // Mirror of the slot chain plus the queue of replies still owed by the unit.
  class cache_scoreboard;
    lmfc_pkg::key_t slot_key[lmfc_pkg::ENTRIES];
    logic           slot_valid[lmfc_pkg::ENTRIES];
    logic [31:0]    slot_handle[lmfc_pkg::ENTRIES];
    logic [15:0]    slot_count[lmfc_pkg::ENTRIES];
    reply_t         owed_replies[$];
    int unsigned    errors;
    int unsigned    checked;
    int unsigned    hits;
    int unsigned    per_action[4];

    function new();
      errors  = 0;
      checked = 0;
      hits    = 0;
      foreach (per_action[i]) per_action[i] = 0;
      clear_all();
    endfunction

    function void clear_all();
      for (int i = 0; i < lmfc_pkg::ENTRIES; i++) begin
        slot_key[i]    = '0;
        slot_valid[i]  = 1'b0;
        slot_handle[i] = '0;
        slot_count[i]  = '0;
      end
    endfunction

    function void move_to_front(int pos);
      lmfc_pkg::key_t k;
      logic           v;
      logic [31:0]    h;
      logic [15:0]    c;
      k = slot_key[pos];
      v = slot_valid[pos];
      h = slot_handle[pos];
      c = slot_count[pos];
      for (int i = pos; i >= 1; i--) begin
        slot_key[i]    = slot_key[i-1];
        slot_valid[i]  = slot_valid[i-1];
        slot_handle[i] = slot_handle[i-1];
        slot_count[i]  = slot_count[i-1];
      end
      slot_key[0]    = k;
      slot_valid[0]  = v;
      slot_handle[0] = h;
      slot_count[0]  = c;
    endfunction

    // Updates the mirror for one request and returns the reply it should produce.
    function reply_t apply_request(request_t r);
      reply_t         rep;
      lmfc_pkg::key_t k;
      int             pos;
      rep = '0;
      k   = lmfc_pkg::key_t'(r.key);
      pos = -1;
      if (r.act == lmfc_pkg::ACT_FLUSH) begin
        clear_all();
        return rep;
      end
      for (int i = 0; i < lmfc_pkg::ENTRIES; i++)
        if (pos < 0 && slot_valid[i] && slot_key[i] == k) pos = i;
      if (pos >= 0) begin
        rep.hit    = 1'b1;
        rep.handle = slot_handle[pos];
        rep.cnt    = slot_count[pos];
        move_to_front(pos);
        if (r.act == lmfc_pkg::ACT_INVALIDATE) begin
          slot_key[0]    = '0;
          slot_valid[0]  = 1'b0;
          slot_handle[0] = '0;
          slot_count[0]  = '0;
        end
      end else if (r.act == lmfc_pkg::ACT_INSERT) begin
        // The last slot is dropped and everything shifts back by one.
        move_to_front(lmfc_pkg::ENTRIES - 1);
        slot_key[0]    = k;
        slot_valid[0]  = 1'b1;
        slot_handle[0] = r.handle;
        slot_count[0]  = r.cnt;
      end
      return rep;
    endfunction

    function void note_request(request_t r);
      per_action[r.act]++;
      owed_replies.push_back(apply_request(r));
    endfunction

    function void check_reply(logic h, logic [31:0] fh, logic [15:0] fc);
      reply_t exp_rep;
      if (owed_replies.size() == 0) begin
        $error("result with no transaction outstanding: hit %0d handle %h count %h",
               h, fh, fc);
        errors++;
        return;
      end
      exp_rep = owed_replies.pop_front();
      checked++;
      if (exp_rep.hit) hits++;
      if (h !== exp_rep.hit) begin
        $error("hit: expected %0d, actual %0d", exp_rep.hit, h);
        errors++;
      end
      if (fh !== exp_rep.handle) begin
        $error("found_handle: expected %h, actual %h", exp_rep.handle, fh);
        errors++;
      end
      if (fc !== exp_rep.cnt) begin
        $error("found_count: expected %h, actual %h", exp_rep.cnt, fc);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic [1:0]  action;
  logic [31:0] key;
  logic [31:0] handle;
  logic [15:0] item_count;
  logic        done;
  logic        hit;
  logic [31:0] found_handle;
  logic [15:0] found_count;

  cache_scoreboard sb = new();
  logic [31:0]     key_pool[12];

  lru_move_to_front_cache_unit uut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .action       (action),
    .key          (key),
    .handle       (handle),
    .item_count   (item_count),
    .done         (done),
    .hit          (hit),
    .found_handle (found_handle),
    .found_count  (found_count)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst && done) sb.check_reply(hit, found_handle, found_count);
  end

  function automatic request_t mk_req(lmfc_pkg::action_t a, logic [31:0] k,
                                      logic [31:0] h, logic [15:0] c);
    request_t r;
    r.act    = a;
    r.key    = k;
    r.handle = h;
    r.cnt    = c;
    return r;
  endfunction

  function automatic request_t random_request();
    request_t    r;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 40)      r.act = lmfc_pkg::ACT_INSERT;
    else if (pick < 78) r.act = lmfc_pkg::ACT_LOOKUP;
    else if (pick < 97) r.act = lmfc_pkg::ACT_INVALIDATE;
    else                r.act = lmfc_pkg::ACT_FLUSH;
    // Keys mostly come from a pool a bit larger than the cache so that hits,
    // promotions and evictions all happen often.
    if ($urandom_range(9) == 0) r.key = $urandom;
    else                        r.key = key_pool[$urandom_range(11)];
    r.handle = $urandom;
    r.cnt    = 16'($urandom);
    return r;
  endfunction

  // Holds start low for a random number of cycles, then offers the transaction
  // until the unit takes it.
  task automatic send_request(input request_t r, input int unsigned idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      start      <= 1'b0;
      key        <= $urandom;
      handle     <= $urandom;
      item_count <= 16'($urandom);
      action     <= 2'($urandom);
      @(posedge clk);
    end
    start      <= 1'b1;
    action     <= r.act;
    key        <= r.key;
    handle     <= r.handle;
    item_count <= r.cnt;
    do @(posedge clk); while (busy);
    sb.note_request(r);
  endtask

  task automatic random_phase(input int unsigned n, input int unsigned idle_pct);
    for (int i = 0; i < n; i++) send_request(random_request(), idle_pct);
  endtask

  initial begin
    rst        <= 1'b1;
    start      <= 1'b0;
    action     <= lmfc_pkg::ACT_LOOKUP;
    key        <= '0;
    handle     <= '0;
    item_count <= '0;
    key_pool[0] = 32'h0000_0000;
    key_pool[1] = 32'hFFFF_FFFF;
    for (int i = 2; i < 12; i++) key_pool[i] = $urandom;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed part: empty cache, extreme keys and payloads, re-insert of a
    // present key, eviction of the oldest entry, invalidate and flush.
    send_request(mk_req(lmfc_pkg::ACT_LOOKUP, 32'h0000_0000, 32'hFFFF_FFFF, 16'hFFFF), 0);
    send_request(mk_req(lmfc_pkg::ACT_INVALIDATE, 32'h0000_0000, 32'h0, 16'h0), 0);
    send_request(mk_req(lmfc_pkg::ACT_FLUSH, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF), 0);
    send_request(mk_req(lmfc_pkg::ACT_INSERT, 32'h0000_0000, 32'hFFFF_FFFF, 16'hFFFF), 0);
    send_request(mk_req(lmfc_pkg::ACT_INSERT, 32'hFFFF_FFFF, 32'h0000_0000, 16'h0000), 0);
    send_request(mk_req(lmfc_pkg::ACT_LOOKUP, 32'h0000_0000, 32'h1234_5678, 16'h1234), 0);
    send_request(mk_req(lmfc_pkg::ACT_INSERT, 32'hFFFF_FFFF, 32'hDEAD_BEEF, 16'hBEEF), 0);
    for (int i = 1; i <= 7; i++)
      send_request(mk_req(lmfc_pkg::ACT_INSERT, 32'(i), 32'h1000_0000 + 32'(i), 16'(i)), 0);
    send_request(mk_req(lmfc_pkg::ACT_LOOKUP, 32'h0000_0000, 32'h0, 16'h0), 0);
    send_request(mk_req(lmfc_pkg::ACT_LOOKUP, 32'hFFFF_FFFF, 32'h0, 16'h0), 0);
    send_request(mk_req(lmfc_pkg::ACT_INVALIDATE, 32'h0000_0004, 32'h0, 16'h0), 0);
    send_request(mk_req(lmfc_pkg::ACT_LOOKUP, 32'h0000_0004, 32'h0, 16'h0), 0);
    // The cleared front slot holds key zero but must not match.
    send_request(mk_req(lmfc_pkg::ACT_LOOKUP, 32'h0000_0000, 32'h0, 16'h0), 0);
    send_request(mk_req(lmfc_pkg::ACT_INSERT, 32'h5555_5555, 32'hAAAA_AAAA, 16'h5555), 0);
    send_request(mk_req(lmfc_pkg::ACT_INSERT, 32'hAAAA_AAAA, 32'h5555_5555, 16'hAAAA), 0);
    send_request(mk_req(lmfc_pkg::ACT_INVALIDATE, 32'hFFFF_FFFF, 32'h0, 16'h0), 0);
    send_request(mk_req(lmfc_pkg::ACT_LOOKUP, 32'h5555_5555, 32'h0, 16'h0), 0);
    send_request(mk_req(lmfc_pkg::ACT_FLUSH, 32'h0, 32'h0, 16'h0), 0);
    send_request(mk_req(lmfc_pkg::ACT_LOOKUP, 32'h0000_0001, 32'h0, 16'h0), 0);

    random_phase(135, 8);
    random_phase(135, 47);
    random_phase(135, 0);

    start <= 1'b0;
    while (sb.owed_replies.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);

    $display("Covered %0d inserts, %0d lookups, %0d invalidates, %0d flushes.",
             sb.per_action[lmfc_pkg::ACT_INSERT], sb.per_action[lmfc_pkg::ACT_LOOKUP],
             sb.per_action[lmfc_pkg::ACT_INVALIDATE], sb.per_action[lmfc_pkg::ACT_FLUSH]);
    $display("Checked %0d results, %0d of them hits, with %0d mismatches.",
             sb.checked, sb.hits, sb.errors);
    if (sb.errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #(12 * 40000);
    $display("FAILED: results differ");
    $finish;
  end

endmodule

@@ lru_move_to_front_cache_unit.f @@
rtl/lmfc_pkg.sv
rtl/lmfc_cell.sv
rtl/lru_move_to_front_cache_unit.sv
rtl/lmfc_checker.sv
sim/lru_move_to_front_cache_unit_tb.sv
